/* hdl/assert_macros.svh */
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define NRMC_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define NRMC_NEVER(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define NRMC_ASSERT(name, clk, rstn, prop)

`define NRMC_NEVER(name, clk, rstn, cond)

`endif

`endif

/* hdl/nrmc_pkg.sv */
package nrmc_pkg;

    localparam int SENTENCE_MAX = 128;
    localparam int FIELD_MAX    = 12;
    localparam int NUM_SLOTS    = 5;
    localparam int STORE_DEPTH  = NUM_SLOTS * FIELD_MAX;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int LEN_W        = $clog2(FIELD_MAX + 1);
    localparam int SLOT_IW      = $clog2(NUM_SLOTS);
    localparam int SLOT_W       = $clog2(NUM_SLOTS + 1);
    localparam int POS_W        = 8;
    localparam int COMMA_W      = 3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [POS_W-1:0]   POS_HDR_M    = 8'd4;
    localparam logic [POS_W-1:0]   POS_HDR_C    = 8'd5;
    localparam logic [COMMA_W-1:0] COMMA_STATUS = 3'd2;
    localparam logic [COMMA_W-1:0] COMMA_FULL   = 3'd7;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_END,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_IW-1:0] slot;
    } slot_map_t;

    // field number after n commas -> store slot
    function automatic slot_map_t slot_of(input logic [COMMA_W-1:0] commas);
        slot_map_t m;
        m.hit  = 1'b1;
        m.slot = '0;
        case (commas)
            3'd1:    m.slot = SLOT_IW'(0);
            3'd3:    m.slot = SLOT_IW'(1);
            3'd4:    m.slot = SLOT_IW'(2);
            3'd5:    m.slot = SLOT_IW'(3);
            3'd6:    m.slot = SLOT_IW'(4);
            default: m.hit  = 1'b0;
        endcase
        return m;
    endfunction

    function automatic logic [STORE_AW-1:0] slot_base(input logic [SLOT_IW-1:0] slot);
        return STORE_AW'(int'(slot) * FIELD_MAX);
    endfunction

endpackage

/* hdl/nrmc_ram.sv */
module nrmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/nmea_rmc_field_extractor.sv */
// NMEA RMC field extractor. Takes one received byte per beat on the s_ side
// and, on the line feed that closes an RMC sentence, sends out the characters
// of time, latitude, N/S, longitude and E/W (in that order), then an end beat
// that carries the fix flag and has tlast set; a sentence with fewer than seven commas
// gives a single error beat instead. Bytes are taken one per cycle while a
// sentence is being parsed. At line end the input stalls while the field
// store (a single-port-read RAM of 5 x 12 bytes) is replayed: each stored
// character is read from the RAM in ST_SCAN, then loaded into the output
// register in ST_LOAD; after each field the scan steps on to the next slot,
// and the end beat closes the run; output back-pressure extends the stall.
// The store needs no clearing after reset.
`include "assert_macros.svh"

module nmea_rmc_field_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_code [7:0], fix_valid [8], zero fill
    output logic [4:0]  m_tuser,   // item_kind [1:0], field_index [4:2]
    output logic        m_tlast
);

    nrmc_pkg::state_t state_reg, state_next;

    logic [nrmc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         in_sent_reg, in_sent_next;
    logic [1:0]                   hdr_reg, hdr_next;
    logic [nrmc_pkg::COMMA_W-1:0] comma_reg, comma_next;
    logic [nrmc_pkg::LEN_W-1:0]   len_reg [nrmc_pkg::NUM_SLOTS];
    logic [nrmc_pkg::LEN_W-1:0]   len_next [nrmc_pkg::NUM_SLOTS];
    logic [7:0]                   status_reg, status_next;
    logic                         fix_reg, fix_next;
    logic [nrmc_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [nrmc_pkg::LEN_W-1:0]   idx_reg, idx_next;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [1:0] kind_reg, kind_next;
    logic [2:0] fidx_reg, fidx_next;
    logic [7:0] char_reg, char_next;
    logic       fixo_reg, fixo_next;
    logic       last_reg, last_next;

    logic                          in_acc;
    logic                          out_free;
    logic                          slot_done;
    logic [nrmc_pkg::SLOT_IW-1:0]  slot_i;
    logic [nrmc_pkg::LEN_W-1:0]    cur_len;
    logic                          line_end_rmc;
    nrmc_pkg::slot_map_t           wmap;

    logic                          ram_we;
    logic [nrmc_pkg::STORE_AW-1:0] ram_waddr;
    logic                          ram_re;
    logic [nrmc_pkg::STORE_AW-1:0] ram_raddr;
    logic [7:0]                    ram_rdata;

    nrmc_ram #(
        .WIDTH (8),
        .DEPTH (nrmc_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == nrmc_pkg::ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign slot_done = (slot_reg == nrmc_pkg::SLOT_W'(nrmc_pkg::NUM_SLOTS));
    assign slot_i    = slot_reg[nrmc_pkg::SLOT_IW-1:0];
    assign cur_len   = slot_done ? '0 : len_reg[slot_i];
    assign wmap      = nrmc_pkg::slot_of(comma_reg);

    assign line_end_rmc = in_acc && (s_tdata == nrmc_pkg::CH_LF) && in_sent_reg
                          && (hdr_reg == 2'b11);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nrmc_pkg::ST_IDLE: begin
                if (line_end_rmc) begin
                    state_next = (comma_reg == nrmc_pkg::COMMA_FULL) ? nrmc_pkg::ST_SCAN
                                                                    : nrmc_pkg::ST_ERR;
                end
            end
            nrmc_pkg::ST_SCAN: begin
                if (slot_done) begin
                    state_next = nrmc_pkg::ST_END;
                end else if (idx_reg < cur_len) begin
                    state_next = nrmc_pkg::ST_LOAD;
                end
            end
            nrmc_pkg::ST_LOAD: begin
                if (out_free) state_next = nrmc_pkg::ST_SCAN;
            end
            nrmc_pkg::ST_END, nrmc_pkg::ST_ERR: begin
                if (out_free) state_next = nrmc_pkg::ST_IDLE;
            end
            default: state_next = nrmc_pkg::ST_IDLE;
        endcase
    end

    // datapath, store access and output register
    always_comb begin
        pos_next      = pos_reg;
        in_sent_next  = in_sent_reg;
        hdr_next      = hdr_reg;
        comma_next    = comma_reg;
        len_next      = len_reg;
        status_next   = status_reg;
        fix_next      = fix_reg;
        slot_next     = slot_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        kind_next     = kind_reg;
        fidx_next     = fidx_reg;
        char_next     = char_reg;
        fixo_next     = fixo_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_waddr     = nrmc_pkg::slot_base(wmap.slot) + nrmc_pkg::STORE_AW'(len_reg[wmap.slot]);
        ram_re        = 1'b0;
        ram_raddr     = nrmc_pkg::slot_base(slot_i) + nrmc_pkg::STORE_AW'(idx_reg);

        case (state_reg)
            nrmc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (s_tdata == nrmc_pkg::CH_DOLLAR) begin
                        pos_next     = nrmc_pkg::POS_W'(1);
                        in_sent_next = 1'b1;
                        hdr_next     = 2'b00;
                        comma_next   = '0;
                        status_next  = '0;
                        for (int i = 0; i < nrmc_pkg::NUM_SLOTS; i++) begin
                            len_next[i] = '0;
                        end
                    end else if (in_sent_reg) begin
                        if (s_tdata == nrmc_pkg::CH_LF) begin
                            in_sent_next = 1'b0;
                            if (hdr_reg == 2'b11 && comma_reg == nrmc_pkg::COMMA_FULL) begin
                                if (status_reg == nrmc_pkg::CH_A) begin
                                    fix_next = 1'b1;
                                end else if (status_reg == nrmc_pkg::CH_V) begin
                                    fix_next = 1'b0;
                                end
                                slot_next = '0;
                                idx_next  = '0;
                            end
                        end else if (pos_reg < nrmc_pkg::POS_W'(nrmc_pkg::SENTENCE_MAX)) begin
                            if (pos_reg == nrmc_pkg::POS_HDR_M && s_tdata == nrmc_pkg::CH_M) begin
                                hdr_next[0] = 1'b1;
                            end
                            if (pos_reg == nrmc_pkg::POS_HDR_C && s_tdata == nrmc_pkg::CH_C) begin
                                hdr_next[1] = 1'b1;
                            end
                            pos_next = pos_reg + 1'b1;
                            if (s_tdata == nrmc_pkg::CH_COMMA) begin
                                if (comma_reg != nrmc_pkg::COMMA_FULL) begin
                                    comma_next = comma_reg + 1'b1;
                                end
                            end else if (comma_reg == nrmc_pkg::COMMA_STATUS) begin
                                // only the first status character counts
                                if (status_reg == 8'd0) status_next = s_tdata;
                            end else if (wmap.hit && len_reg[wmap.slot]
                                         < nrmc_pkg::LEN_W'(nrmc_pkg::FIELD_MAX)) begin
                                ram_we = 1'b1;
                                len_next[wmap.slot] = len_reg[wmap.slot] + 1'b1;
                            end
                        end
                    end
                end
            end
            nrmc_pkg::ST_SCAN: begin
                if (!slot_done) begin
                    if (idx_reg < cur_len) begin
                        ram_re = 1'b1;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                        idx_next  = '0;
                    end
                end
            end
            nrmc_pkg::ST_LOAD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    kind_next     = nrmc_pkg::KIND_CHAR;
                    fidx_next     = 3'(slot_reg);
                    char_next     = ram_rdata;
                    fixo_next     = fix_reg;
                    last_next     = 1'b0;
                    idx_next      = idx_reg + 1'b1;
                end
            end
            nrmc_pkg::ST_END, nrmc_pkg::ST_ERR: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    kind_next     = (state_reg == nrmc_pkg::ST_END) ? nrmc_pkg::KIND_END
                                                                    : nrmc_pkg::KIND_ERR;
                    fidx_next     = 3'd0;
                    char_next     = 8'd0;
                    fixo_next     = fix_reg;
                    last_next     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= nrmc_pkg::ST_IDLE;
            pos_reg      <= '0;
            in_sent_reg  <= 1'b0;
            hdr_reg      <= 2'b00;
            comma_reg    <= '0;
            status_reg   <= '0;
            fix_reg      <= 1'b0;
            slot_reg     <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < nrmc_pkg::NUM_SLOTS; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            in_sent_reg  <= in_sent_next;
            hdr_reg      <= hdr_next;
            comma_reg    <= comma_next;
            status_reg   <= status_next;
            fix_reg      <= fix_next;
            slot_reg     <= slot_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
            len_reg      <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        fidx_reg <= fidx_next;
        char_reg <= char_next;
        fixo_reg <= fixo_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, fixo_reg, char_reg};
    assign m_tuser  = {fidx_reg, kind_reg};
    assign m_tlast  = last_reg;

    // the store is only written while parsing, never during replay
    `NRMC_NEVER(a_no_write_in_replay, aclk, aresetn,
                ram_we && state_reg != nrmc_pkg::ST_IDLE)
    // ST_LOAD is entered only right after a store read was issued
    `NRMC_ASSERT(a_load_after_read, aclk, aresetn,
                 (state_reg == nrmc_pkg::ST_SCAN && state_next == nrmc_pkg::ST_LOAD)
                 |=> (state_reg == nrmc_pkg::ST_LOAD && $past(ram_re)))
    // replay index never runs past the captured length
    `NRMC_ASSERT(a_idx_in_range, aclk, aresetn,
                 (state_reg == nrmc_pkg::ST_SCAN && !slot_done) |-> (idx_reg <= cur_len))
    // only end and error beats close a run
    `NRMC_ASSERT(a_last_kind, aclk, aresetn,
                 (m_tvalid_reg && last_reg) |-> (kind_reg != nrmc_pkg::KIND_CHAR))
    // a new output beat never overwrites one still waiting
    `NRMC_ASSERT(a_no_overwrite, aclk, aresetn,
                 (m_tvalid_reg && !m_tready) |=> $stable(char_reg) && $stable(kind_reg))

endmodule

/* bench/tb_nmea_rmc_field_extractor.sv */
module tb_nmea_rmc_field_extractor;

    localparam int NUM_FIELDS     = 5;
    localparam int TARGET_BYTES   = 330;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] fld;
        logic [7:0] code;
        logic       fix;
        logic       last;
    } rmc_beat_t;

    typedef enum int {
        LINE_GOOD,
        LINE_NOISE,
        LINE_RESTART,
        LINE_SHORT,
        LINE_OTHER,
        LINE_LONG,
        LINE_WIDE,
        LINE_KINDS
    } line_kind_e;

    class rmc_scoreboard;
        logic [7:0] pos;
        logic       active;
        logic [1:0] hdr;
        logic [2:0] commas;
        logic [7:0] chars [NUM_FIELDS * nrmc_pkg::FIELD_MAX];
        logic [3:0] lens [NUM_FIELDS];
        logic [7:0] status;
        logic       fix;
        rmc_beat_t  expected_q [$];
        int         errors;
        int         beats_checked;
        int         fixes_out;
        int         error_items;

        function new();
            pos = '0;
            active = 1'b0;
            hdr = '0;
            commas = '0;
            status = '0;
            fix = 1'b0;
            foreach (lens[i]) lens[i] = '0;
            errors = 0;
            beats_checked = 0;
            fixes_out = 0;
            error_items = 0;
        endfunction

        function void push_beat(logic [1:0] kind, logic [2:0] fld, logic [7:0] code,
                                logic last);
            rmc_beat_t e;
            e.kind = kind;
            e.fld  = fld;
            e.code = code;
            e.fix  = fix;
            e.last = last;
            expected_q.push_back(e);
        endfunction

        // one accepted byte -> expected beats, if any
        function void note_byte(logic [7:0] b);
            int slot;
            if (b == nrmc_pkg::CH_DOLLAR) begin
                pos = 8'd1;
                active = 1'b1;
                hdr = '0;
                commas = '0;
                status = '0;
                foreach (lens[i]) lens[i] = '0;
                return;
            end
            if (!active)
                return;
            if (b == nrmc_pkg::CH_LF) begin
                active = 1'b0;
                if (hdr != 2'b11)
                    return;
                if (commas != nrmc_pkg::COMMA_FULL) begin
                    push_beat(nrmc_pkg::KIND_ERR, 3'd0, 8'd0, 1'b1);
                    error_items++;
                    return;
                end
                if (status == nrmc_pkg::CH_A)
                    fix = 1'b1;
                else if (status == nrmc_pkg::CH_V)
                    fix = 1'b0;
                for (int f = 0; f < NUM_FIELDS; f++)
                    for (int i = 0; i < lens[f]; i++)
                        push_beat(nrmc_pkg::KIND_CHAR, 3'(f),
                                  chars[f * nrmc_pkg::FIELD_MAX + i], 1'b0);
                push_beat(nrmc_pkg::KIND_END, 3'd0, 8'd0, 1'b1);
                fixes_out++;
                return;
            end
            if (pos >= nrmc_pkg::SENTENCE_MAX)
                return;
            if (pos == nrmc_pkg::POS_HDR_M && b == nrmc_pkg::CH_M)
                hdr[0] = 1'b1;
            if (pos == nrmc_pkg::POS_HDR_C && b == nrmc_pkg::CH_C)
                hdr[1] = 1'b1;
            pos++;
            if (b == nrmc_pkg::CH_COMMA) begin
                if (commas != nrmc_pkg::COMMA_FULL)
                    commas++;
                return;
            end
            // status keeps its first char; a zero byte counts as still empty
            if (commas == nrmc_pkg::COMMA_STATUS) begin
                if (status == 8'd0)
                    status = b;
                return;
            end
            case (commas)
                3'd1:    slot = 0;
                3'd3:    slot = 1;
                3'd4:    slot = 2;
                3'd5:    slot = 3;
                3'd6:    slot = 4;
                default: slot = -1;
            endcase
            if (slot >= 0 && lens[slot] < nrmc_pkg::FIELD_MAX) begin
                chars[slot * nrmc_pkg::FIELD_MAX + lens[slot]] = b;
                lens[slot]++;
            end
        endfunction

        function void mismatch(string what, logic [7:0] want_v, logic [7:0] got_v);
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
        endfunction

        function void check_beat(rmc_beat_t got);
            rmc_beat_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, got kind %0d field %0d char %h",
                         $time, got.kind, got.fld, got.code);
                return;
            end
            want = expected_q.pop_front();
            beats_checked++;
            if (got.kind !== want.kind)
                mismatch("item_kind", 8'(want.kind), 8'(got.kind));
            if (got.fld !== want.fld)
                mismatch("field_index", 8'(want.fld), 8'(got.fld));
            if (got.code !== want.code)
                mismatch("char_code", want.code, got.code);
            if (got.fix !== want.fix)
                mismatch("fix_valid", 8'(want.fix), 8'(got.fix));
            if (got.last !== want.last)
                mismatch("tlast", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // char_code [7:0], fix_valid [8], zero fill
    logic [4:0]  m_tuser;   // item_kind [1:0], field_index [4:2]
    logic        m_tlast;

    rmc_scoreboard sb;
    logic [7:0]    line_q [$];
    bit            calm = 1'b0;
    int            fed_bytes = 0;
    int            noise_bytes = 0;
    int            idle_cycles = 0;
    int            ready_left = 0;

    nmea_rmc_field_extractor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        int g;
        if (ready_left > 0) begin
            ready_left--;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                m_tready <= 1'b1;
                ready_left = $urandom_range(0, 7);
            end else begin
                m_tready <= 1'b0;
                ready_left = g - 1;
            end
        end
    end

    // sample mid-cycle: what is seen here is what the next rising edge takes
    always @(negedge aclk) begin
        rmc_beat_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                got = {m_tuser[1:0], m_tuser[4:2], m_tdata[7:0], m_tdata[8], m_tlast};
                sb.check_beat(got);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: watchdog, no beat for %0d cycles, %0d beats outstanding",
                             $time, idle_cycles, sb.expected_q.size());
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int g;
        bit rdy;
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
    endtask

    task automatic send_line(input bit counted);
        calm = ($urandom_range(0, 3) == 0);
        foreach (line_q[i])
            send_byte(line_q[i]);
        if (counted)
            fed_bytes += line_q.size();
        else
            noise_bytes += line_q.size();
        line_q.delete();
    endtask

    function automatic logic [7:0] field_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0) begin
            do c = 8'($urandom_range(0, 255));
            while (c == nrmc_pkg::CH_COMMA || c == nrmc_pkg::CH_DOLLAR
                   || c == nrmc_pkg::CH_LF);
        end else begin
            do c = 8'($urandom_range(8'h21, 8'h7e));
            while (c == nrmc_pkg::CH_COMMA || c == nrmc_pkg::CH_DOLLAR);
        end
        return c;
    endfunction

    function automatic int field_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, 3);
        if (r < 9)
            return $urandom_range(4, nrmc_pkg::FIELD_MAX);
        return $urandom_range(nrmc_pkg::FIELD_MAX + 1, nrmc_pkg::FIELD_MAX + 3);
    endfunction

    task automatic push_str(input string s);
        foreach (s[i])
            line_q.push_back(8'(s[i]));
    endtask

    task automatic push_chars(input int n);
        repeat (n) line_q.push_back(field_char());
    endtask

    task automatic push_header(input bit rmc);
        logic [7:0] c4, c5;
        line_q.push_back(nrmc_pkg::CH_DOLLAR);
        repeat (3) line_q.push_back(8'($urandom_range(65, 90)));
        if (rmc) begin
            c4 = nrmc_pkg::CH_M;
            c5 = nrmc_pkg::CH_C;
        end else begin
            do begin
                c4 = 8'($urandom_range(65, 90));
                c5 = 8'($urandom_range(65, 90));
                if ($urandom_range(0, 1))
                    c4 = nrmc_pkg::CH_M;
                else if ($urandom_range(0, 1))
                    c5 = nrmc_pkg::CH_C;
            end while (c4 == nrmc_pkg::CH_M && c5 == nrmc_pkg::CH_C);
        end
        line_q.push_back(c4);
        line_q.push_back(c5);
    endtask

    task automatic push_rmc(input bit wide);
        push_header(1'b1);
        for (int f = 1; f <= 6; f++) begin
            line_q.push_back(nrmc_pkg::CH_COMMA);
            if (f == 2) begin
                case ($urandom_range(0, 5))
                    0: ;
                    1, 2: line_q.push_back(nrmc_pkg::CH_A);
                    3: line_q.push_back(nrmc_pkg::CH_V);
                    4: line_q.push_back(field_char());
                    default: begin
                        line_q.push_back($urandom_range(0, 1) ? nrmc_pkg::CH_V
                                                              : nrmc_pkg::CH_A);
                        push_chars($urandom_range(1, 2));
                    end
                endcase
            end else begin
                push_chars(wide ? $urandom_range(nrmc_pkg::FIELD_MAX - 1,
                                                 nrmc_pkg::FIELD_MAX + 4)
                                : field_len());
            end
        end
        repeat ($urandom_range(1, 4)) begin
            line_q.push_back(nrmc_pkg::CH_COMMA);
            push_chars($urandom_range(0, 3));
        end
        if ($urandom_range(0, 1))
            push_str("*4F\r");
        line_q.push_back(nrmc_pkg::CH_LF);
    endtask

    task automatic build_line(input line_kind_e kind);
        case (kind)
            LINE_NOISE: begin
                repeat ($urandom_range(3, 12)) begin
                    logic [7:0] c;
                    do c = 8'($urandom_range(0, 255));
                    while (c == nrmc_pkg::CH_DOLLAR);
                    line_q.push_back(c);
                end
            end
            LINE_RESTART: begin
                // partial sentence with a valid status, cut off by a new start
                push_header(1'b1);
                line_q.push_back(nrmc_pkg::CH_COMMA);
                push_chars($urandom_range(0, 5));
                line_q.push_back(nrmc_pkg::CH_COMMA);
                line_q.push_back(nrmc_pkg::CH_A);
                line_q.push_back(nrmc_pkg::CH_COMMA);
                push_chars($urandom_range(0, 4));
                push_rmc(1'b0);
            end
            LINE_SHORT: begin
                push_header(1'b1);
                repeat ($urandom_range(0, 6)) begin
                    line_q.push_back(nrmc_pkg::CH_COMMA);
                    push_chars(field_len());
                end
                line_q.push_back(nrmc_pkg::CH_LF);
            end
            LINE_OTHER: begin
                if ($urandom_range(0, 2) == 0) begin
                    // ends before the header is complete
                    line_q.push_back(nrmc_pkg::CH_DOLLAR);
                    push_chars($urandom_range(0, 4));
                end else begin
                    push_header(1'b0);
                    repeat ($urandom_range(6, 9)) begin
                        line_q.push_back(nrmc_pkg::CH_COMMA);
                        push_chars($urandom_range(0, 3));
                    end
                end
                line_q.push_back(nrmc_pkg::CH_LF);
            end
            LINE_LONG: begin
                push_header(1'b1);
                if ($urandom_range(0, 1)) begin
                    for (int f = 1; f <= 7; f++) begin
                        line_q.push_back(nrmc_pkg::CH_COMMA);
                        if (f == 2)
                            line_q.push_back($urandom_range(0, 1) ? nrmc_pkg::CH_A
                                                                  : nrmc_pkg::CH_V);
                        else
                            push_chars($urandom_range(0, 4));
                    end
                    while (line_q.size() < nrmc_pkg::SENTENCE_MAX + 12)
                        line_q.push_back($urandom_range(0, 7) == 0 ? nrmc_pkg::CH_COMMA
                                                                   : field_char());
                    line_q.push_back(nrmc_pkg::CH_LF);
                end else begin
                    // the commas fall past the end and never count
                    line_q.push_back(nrmc_pkg::CH_COMMA);
                    while (line_q.size() < nrmc_pkg::SENTENCE_MAX + 2)
                        line_q.push_back(field_char());
                    push_str(",A,1,N,2,E,\n");
                end
            end
            LINE_WIDE: push_rmc(1'b1);
            default:   push_rmc(1'b0);
        endcase
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // field extremes and a valid fix, then an error line that keeps it
        push_str("$GPRMC,");
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        push_str(",A,2,N,3,E,\n");
        send_line(1'b1);
        push_str("$GPRMC,\n");
        send_line(1'b1);

        for (int k = 0; k < LINE_KINDS; k++) begin
            build_line(line_kind_e'(k));
            send_line(line_kind_e'(k) != LINE_NOISE);
        end

        while (fed_bytes < TARGET_BYTES) begin
            line_kind_e kind;
            case ($urandom_range(0, 9))
                5:       kind = LINE_NOISE;
                6:       kind = LINE_RESTART;
                7:       kind = LINE_SHORT;
                8:       kind = LINE_OTHER;
                9:       kind = LINE_WIDE;
                default: kind = LINE_GOOD;
            endcase
            build_line(kind);
            send_line(kind != LINE_NOISE);
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("fed %0d sentence bytes and %0d stray bytes, checked %0d result beats",
                 fed_bytes, noise_bytes, sb.beats_checked);
        $display("%0d sentences emitted fields, %0d ended in a parse error, %0d mismatches",
                 sb.fixes_out, sb.error_items, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
